// ----- rtl/fat_cluster_chain_lookup_defines.svh -----
// Assertion macros shared by the FAT cluster-chain lookup RTL.
`ifndef FAT_CLUSTER_CHAIN_LOOKUP_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fcl_pkg.sv -----
// Types, constants and helpers for the FAT cluster-chain lookup.
`default_nettype none
package fcl_pkg;

   localparam int unsigned SECTOR_SIZE_MAX = 4096;
   localparam int unsigned DSR_W = $clog2(SECTOR_SIZE_MAX) + 1;
   localparam int unsigned REM_W = DSR_W - 1;
   localparam int unsigned DVD_W = 32;
   localparam int unsigned BITS_PER_STAGE = 4;
   localparam int unsigned DIV_STAGES = DVD_W / BITS_PER_STAGE;

   localparam logic [31:0] FAT12_LIMIT = 32'd4085;
   localparam logic [31:0] FAT16_LIMIT = 32'd65525;
   localparam logic [11:0] FAT12_MASK = 12'hFFF;
   localparam logic [11:0] FAT12_EOC = 12'hFF8;
   localparam logic [11:0] FAT12_BAD = 12'hFF7;
   localparam logic [15:0] FAT16_EOC = 16'hFFF8;
   localparam logic [15:0] FAT16_BAD = 16'hFFF7;
   localparam logic [27:0] FAT32_MASK = 28'hFFFFFFF;
   localparam logic [27:0] FAT32_EOC = 28'hFFFFFF8;
   localparam logic [27:0] FAT32_BAD = 28'hFFFFFF7;

   typedef enum logic [1:0] {
      KIND_FAT12 = 2'd0,
      KIND_FAT16 = 2'd1,
      KIND_FAT32 = 2'd2
   } fat_kind_type;

   typedef enum logic [1:0] {
      STS_VALID = 2'd0,
      STS_EOC   = 2'd1,
      STS_BAD   = 2'd2
   } entry_status_type;

   typedef enum logic {
      REQ_LOCATE = 1'b0,
      REQ_DECODE = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_BPS   = 3'd0,
      CSR_SPC   = 3'd1,
      CSR_RSVD  = 3'd2,
      CSR_NFATS = 3'd3,
      CSR_ROOT  = 3'd4,
      CSR_TOTAL = 3'd5,
      CSR_FATSZ = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      GEO_ROOT_INIT,
      GEO_ROOT_DIV,
      GEO_MUL,
      GEO_FDS,
      GEO_CLU_INIT,
      GEO_CLU_DIV,
      GEO_DONE
   } geo_state_type;

   typedef struct packed {
      logic [DSR_W-1:0] sector_size;   // already clamped to SECTOR_SIZE_MAX
      logic [7:0]       clus_secs;
      logic [15:0]      rsvd_secs;
      logic [7:0]       fat_copies;
      logic [15:0]      root_entries;
      logic [31:0]      vol_secs;
      logic [31:0]      fat_secs;
   } cfg_type;

   typedef struct packed {
      logic         ready;
      logic [31:0]  data_start;
      fat_kind_type kind;
   } geo_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DVD_W-1:0] dvd;
   } div_type;

   // One restoring division step: quotient bit shifts into dvd lsb.
   function automatic div_type div_step(div_type cur, logic [DSR_W-1:0] dsr);
      logic [DSR_W-1:0] r2;
      div_type          nxt;
      r2 = {cur.rem, cur.dvd[DVD_W-1]};
      if (r2 >= dsr) begin
         nxt.rem = REM_W'(r2 - dsr);
         nxt.dvd = {cur.dvd[DVD_W-2:0], 1'b1};
      end else begin
         nxt.rem = r2[REM_W-1:0];
         nxt.dvd = {cur.dvd[DVD_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/fat_cluster_chain_lookup.sv -----
// Top level of the FAT cluster-chain lookup: config, geometry and lookup pipeline.
// An accepted request passes the input register, stage 0, the divider stages and the
// output register to rsp_tvalid. Throughput: one item per cycle unless rsp_tready
// stalls or geometry is not ready; the 8-stage divider (4 quotient bits per stage)
// for the FAT byte offset sets the depth. After reset or any register write the
// geometry sequencer runs two serial divisions; req_tready stays low until it is done.
// Reset is synchronous active high; registers return to their boot defaults.
`default_nettype none
`include "fat_cluster_chain_lookup_defines.svh"
module fat_cluster_chain_lookup
   import fcl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // config write port
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata,
   // request items
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // cluster[31:0], raw_entry[63:32]
   input  wire logic         req_tuser,   // req_type
   // response items
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [111:0]      rsp_tdata,   // fat_sec[31:0], entry_offset[43:32],
                                          // cluster_lba[75:44], next_cluster[103:76],
                                          // entry_status[105:104], zero fill
   output logic [1:0]        rsp_tuser    // fat_type
);

   // ---------------- configuration registers ----------------
   logic [12:0] bps_ff;
   logic [7:0]  spc_ff;
   logic [15:0] rsvd_ff;
   logic [7:0]  nfats_ff;
   logic [15:0] root_ff;
   logic [31:0] total_ff;
   logic [31:0] fatsz_ff;
   logic        cfg_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff   <= 13'd512;
         spc_ff   <= 8'd1;
         rsvd_ff  <= 16'd1;
         nfats_ff <= 8'd2;
         root_ff  <= 16'd512;
         total_ff <= '0;
         fatsz_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BPS:   bps_ff   <= csr_wdata[12:0];
            CSR_SPC:   spc_ff   <= csr_wdata[7:0];
            CSR_RSVD:  rsvd_ff  <= csr_wdata[15:0];
            CSR_NFATS: nfats_ff <= csr_wdata[7:0];
            CSR_ROOT:  root_ff  <= csr_wdata[15:0];
            CSR_TOTAL: total_ff <= csr_wdata;
            CSR_FATSZ: fatsz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // unknown index writes nothing and leaves geometry alone
   always_comb begin
      unique case (csr_addr) inside
         CSR_BPS, CSR_SPC, CSR_RSVD, CSR_NFATS,
         CSR_ROOT, CSR_TOTAL, CSR_FATSZ: cfg_hit = csr_we;
         default:                        cfg_hit = 1'b0;
      endcase
   end

   cfg_type cfg;
   assign cfg.sector_size = (bps_ff > 13'(SECTOR_SIZE_MAX)) ? DSR_W'(SECTOR_SIZE_MAX)
                                                            : DSR_W'(bps_ff);
   assign cfg.clus_secs    = spc_ff;
   assign cfg.rsvd_secs    = rsvd_ff;
   assign cfg.fat_copies   = nfats_ff;
   assign cfg.root_entries = root_ff;
   assign cfg.vol_secs     = total_ff;
   assign cfg.fat_secs     = fatsz_ff;

   geo_type geo;

   fcl_geom u_geom (
      .clock (clock),
      .reset (reset),
      .start (cfg_hit),
      .cfg   (cfg),
      .geo   (geo)
   );

   // ---------------- lookup pipeline ----------------
   // Whole pipe advances together; the output register is the last stage.
   typedef struct packed {
      logic             vld;
      req_kind_type     rtype;
      fat_kind_type     kind;
      div_type          div;
      logic [31:0]      lba;
      logic [27:0]      nxt;
      entry_status_type sts;
   } stage_type;

   logic        adv;
   logic        rsp_vld_ff;
   logic        in_vld_ff;
   req_kind_type in_rtype_ff;
   fat_kind_type in_kind_ff;
   logic [31:0] in_cluster_ff;
   logic [31:0] in_raw_ff;

   stage_type   st_ff [0:DIV_STAGES];
   stage_type   st0_in;
   stage_type   stn_in [1:DIV_STAGES];

   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv && geo.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_tvalid && req_tready;
      end
      if (adv) begin
         in_rtype_ff   <= req_kind_type'(req_tuser);
         in_kind_ff    <= geo.kind;
         in_cluster_ff <= req_tdata[31:0];
         in_raw_ff     <= req_tdata[63:32];
      end
   end

   // entry byte offset, decode of the raw entry, cluster LBA product
   logic [15:0] raw16;
   logic [11:0] n12;
   always_comb begin
      st0_in       = '0;
      st0_in.vld   = in_vld_ff;
      st0_in.rtype = in_rtype_ff;
      st0_in.kind  = in_kind_ff;
      raw16        = in_raw_ff[15:0];
      n12          = in_cluster_ff[0] ? raw16[15:4] : (raw16[11:0] & FAT12_MASK);
      st0_in.sts   = STS_VALID;
      case (in_kind_ff)
         KIND_FAT12: begin
            st0_in.div.dvd = in_cluster_ff + {1'b0, in_cluster_ff[31:1]};
            st0_in.nxt     = 28'(n12);
            if (n12 >= FAT12_EOC) st0_in.sts = STS_EOC;
            if (n12 == FAT12_BAD) st0_in.sts = STS_BAD;
         end
         KIND_FAT16: begin
            st0_in.div.dvd = {in_cluster_ff[30:0], 1'b0};
            st0_in.nxt     = 28'(raw16);
            if (raw16 >= FAT16_EOC) st0_in.sts = STS_EOC;
            if (raw16 == FAT16_BAD) st0_in.sts = STS_BAD;
         end
         default: begin
            st0_in.div.dvd = {in_cluster_ff[29:0], 2'b00};
            st0_in.nxt     = in_raw_ff[27:0] & FAT32_MASK;
            if (st0_in.nxt >= FAT32_EOC) st0_in.sts = STS_EOC;
            if (st0_in.nxt == FAT32_BAD) st0_in.sts = STS_BAD;
         end
      endcase
      st0_in.lba = 32'((in_cluster_ff - 32'd2) * 32'(spc_ff));
   end

   // divider stages; the first also adds the first data sector
   always_comb begin
      for (int s = 1; s <= DIV_STAGES; s++) begin
         stn_in[s] = st_ff[s-1];
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            stn_in[s].div = div_step(stn_in[s].div, cfg.sector_size);
         end
         if (s == 1) stn_in[s].lba = st_ff[0].lba + geo.data_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) st_ff[s].vld <= 1'b0;
      end else if (adv) begin
         st_ff[0].vld <= st0_in.vld;
         for (int s = 1; s <= DIV_STAGES; s++) st_ff[s].vld <= stn_in[s].vld;
      end
      if (adv) begin
         st_ff[0][$bits(stage_type)-2:0] <= st0_in[$bits(stage_type)-2:0];
         for (int s = 1; s <= DIV_STAGES; s++) begin
            st_ff[s][$bits(stage_type)-2:0] <= stn_in[s][$bits(stage_type)-2:0];
         end
      end
   end

   // ---------------- output register ----------------
   stage_type   last;
   logic [31:0] fsec_in, fsec_ff;
   logic [11:0] eoff_in, eoff_ff;
   logic [31:0] lba_in, lba_ff;
   logic [27:0] nxt_in, nxt_ff;
   logic [1:0]  sts_in, sts_ff;
   logic [1:0]  kind_ff;

   assign last = st_ff[DIV_STAGES];

   always_comb begin
      fsec_in = '0;
      eoff_in = '0;
      lba_in  = '0;
      nxt_in  = '0;
      sts_in  = STS_VALID;
      if (last.rtype == REQ_LOCATE) begin
         lba_in = last.lba;
         if (cfg.sector_size == '0) begin
            fsec_in = 32'(rsvd_ff);
         end else begin
            fsec_in = 32'(rsvd_ff) + last.div.dvd;
            eoff_in = 12'(last.div.rem);
         end
      end else begin
         nxt_in = last.nxt;
         sts_in = last.sts;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= last.vld;
      end
      if (adv) begin
         fsec_ff <= fsec_in;
         eoff_ff <= eoff_in;
         lba_ff  <= lba_in;
         nxt_ff  <= nxt_in;
         sts_ff  <= sts_in;
         kind_ff <= last.kind;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, sts_ff, nxt_ff, lba_ff, eoff_ff, fsec_ff};
   assign rsp_tuser  = kind_ff;

   // ---------------- checks ----------------
   `FCL_ASSERT_NOW(a_accept_geo, clock, reset, req_tvalid && req_tready, geo.ready, "early item")
   `FCL_ASSERT_NEXT(a_cfg_geo, clock, reset, cfg_hit, !geo.ready, "geometry kept after write")
   `FCL_ASSERT_NOW(a_loc_next, clock, reset, rsp_vld_ff && fsec_ff != '0, nxt_ff == '0, "next on locate")
   `FCL_ASSERT_NOW(a_dec_addr, clock, reset, rsp_vld_ff && sts_ff != STS_VALID, lba_ff == '0, "lba on decode")

endmodule
`default_nettype wire

// ----- rtl/fcl_geom.sv -----
// Geometry sequencer: root sectors, first data sector, cluster count, FAT type.
`default_nettype none
module fcl_geom
   import fcl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire cfg_type cfg,
   output geo_type      geo
);

   geo_state_type    state_ff, state_in;
   div_type          div_ff, div_in, div_step_res;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [31:0]      root_ff, root_in;
   logic [31:0]      prod_ff, prod_in;
   logic [31:0]      fds_ff, fds_in;
   fat_kind_type     kind_ff, kind_in;

   assign div_step_res = div_step(div_ff, dsr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEO_ROOT_INIT;
         fds_ff   <= '0;
         kind_ff  <= KIND_FAT12;
      end else begin
         state_ff <= state_in;
         fds_ff   <= fds_in;
         kind_ff  <= kind_in;
      end
      div_ff  <= div_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      state_in = state_ff;
      div_in   = div_ff;
      dsr_in   = dsr_ff;
      cnt_in   = cnt_ff;
      root_in  = root_ff;
      prod_in  = prod_ff;
      fds_in   = fds_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         GEO_ROOT_INIT: begin
            div_in.rem = '0;
            div_in.dvd = {11'd0, cfg.root_entries, 5'd0}
                         + 32'(cfg.sector_size) - 32'd1;
            dsr_in   = cfg.sector_size;
            cnt_in   = '0;
            state_in = GEO_ROOT_DIV;
         end
         GEO_ROOT_DIV: begin
            div_in = div_step_res;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               root_in  = (dsr_ff == '0) ? 32'd0 : div_step_res.dvd;
               state_in = GEO_MUL;
            end
         end
         GEO_MUL: begin
            prod_in  = 32'(cfg.fat_secs * 32'(cfg.fat_copies));
            state_in = GEO_FDS;
         end
         GEO_FDS: begin
            fds_in   = 32'(cfg.rsvd_secs) + prod_ff + root_ff;
            state_in = GEO_CLU_INIT;
         end
         GEO_CLU_INIT: begin
            div_in.rem = '0;
            div_in.dvd = cfg.vol_secs - fds_ff;
            dsr_in   = DSR_W'(cfg.clus_secs);
            cnt_in   = '0;
            state_in = GEO_CLU_DIV;
         end
         GEO_CLU_DIV: begin
            div_in = div_step_res;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               // zero sectors per cluster means zero clusters
               if (dsr_ff == '0 || div_step_res.dvd < FAT12_LIMIT) kind_in = KIND_FAT12;
               else if (div_step_res.dvd < FAT16_LIMIT)            kind_in = KIND_FAT16;
               else                                                kind_in = KIND_FAT32;
               state_in = GEO_DONE;
            end
         end
         GEO_DONE: begin
            state_in = GEO_DONE;
         end
         default: begin
            state_in = GEO_ROOT_INIT;
         end
      endcase
      if (start) state_in = GEO_ROOT_INIT;
   end

   assign geo.ready      = (state_ff == GEO_DONE);
   assign geo.data_start = fds_ff;
   assign geo.kind       = kind_ff;

endmodule
`default_nettype wire

// ----- verif/fcl_checker.sv -----
// Response checker for the FAT cluster-chain lookup: predicts each item and compares.
`default_nettype none
module fcl_checker
   import fcl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [63:0]  req_tdata,
   input  wire logic         req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [111:0] rsp_tdata,
   input  wire logic [1:0]   rsp_tuser,
   output int                fail_count,
   output int                pending,
   output int                rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] fat_sec;
      logic [11:0] entry_offset;
      logic [31:0] cluster_lba;
      logic [27:0] next_cluster;
      logic [1:0]  entry_status;
      logic [1:0]  fat_type;
   } lookup_result_type;

   logic [31:0] bps, spc, rsvd, nfats, root_cnt, tot_sec, fat_sz;
   logic [31:0] data_start;
   fat_kind_type kind;
   logic        geo_valid;
   lookup_result_type expected_q[$];

   function automatic logic [31:0] sector_bytes();
      return (bps > SECTOR_SIZE_MAX) ? SECTOR_SIZE_MAX : bps;
   endfunction

   task automatic refresh_geometry();
      logic [31:0] d, root_secs, clusters;
      d = sector_bytes();
      root_secs = 0;
      clusters = 0;
      if (d != 0) root_secs = (root_cnt * 32 + (d - 1)) / d;
      data_start = rsvd + nfats * fat_sz + root_secs;
      if (spc != 0) clusters = (tot_sec - data_start) / spc;
      if (clusters < FAT12_LIMIT) kind = KIND_FAT12;
      else if (clusters < FAT16_LIMIT) kind = KIND_FAT16;
      else kind = KIND_FAT32;
      geo_valid = 1'b1;
   endtask

   task automatic predict_lookup(input req_kind_type rk, input logic [31:0] clu,
                                 input logic [31:0] raw);
      lookup_result_type r;
      logic [31:0] d, off, w;
      r = '{default: '0};
      if (!geo_valid) refresh_geometry();
      if (rk == REQ_LOCATE) begin
         d = sector_bytes();
         case (kind)
            KIND_FAT12: off = clu + clu / 2;
            KIND_FAT16: off = clu * 2;
            default:    off = clu * 4;
         endcase
         r.fat_sec = rsvd;
         if (d != 0) begin
            r.fat_sec = rsvd + off / d;
            r.entry_offset = 12'(off % d);
         end
         r.cluster_lba = data_start + (clu - 2) * spc;
      end else begin
         r.entry_status = STS_VALID;
         if (kind == KIND_FAT12) begin
            w = raw & 32'hFFFF;
            w = clu[0] ? (w >> 4) : (w & 32'hFFF);
            if (w >= FAT12_EOC) r.entry_status = STS_EOC;
            if (w == FAT12_BAD) r.entry_status = STS_BAD;
         end else if (kind == KIND_FAT16) begin
            w = raw & 32'hFFFF;
            if (w >= FAT16_EOC) r.entry_status = STS_EOC;
            if (w == FAT16_BAD) r.entry_status = STS_BAD;
         end else begin
            w = raw & 32'h0FFFFFFF;
            if (w >= FAT32_EOC) r.entry_status = STS_EOC;
            if (w == FAT32_BAD) r.entry_status = STS_BAD;
         end
         r.next_cluster = w[27:0];
      end
      r.fat_type = kind;
      expected_q.push_back(r);
   endtask

   always @(posedge clock) begin
      lookup_result_type e;
      if (reset) begin
         bps = 512; spc = 1; rsvd = 1; nfats = 2; root_cnt = 512;
         tot_sec = 0; fat_sz = 0; data_start = 0; kind = KIND_FAT12;
         geo_valid = 1'b0;
         expected_q.delete();
         fail_count = 0;
         rsp_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_BPS:   bps = csr_wdata & 32'h1FFF;
               CSR_SPC:   spc = csr_wdata & 32'hFF;
               CSR_RSVD:  rsvd = csr_wdata & 32'hFFFF;
               CSR_NFATS: nfats = csr_wdata & 32'hFF;
               CSR_ROOT:  root_cnt = csr_wdata & 32'hFFFF;
               CSR_TOTAL: tot_sec = csr_wdata;
               CSR_FATSZ: fat_sz = csr_wdata;
               default: ;
            endcase
            geo_valid = 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_q.size() == 0) begin
               $error("unexpected response item");
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_tdata[31:0] !== e.fat_sec) begin
                  $error("fat_sec exp %h got %h", e.fat_sec, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[43:32] !== e.entry_offset) begin
                  $error("entry_offset exp %h got %h", e.entry_offset, rsp_tdata[43:32]);
                  fail_count++;
               end
               if (rsp_tdata[75:44] !== e.cluster_lba) begin
                  $error("cluster_lba exp %h got %h", e.cluster_lba, rsp_tdata[75:44]);
                  fail_count++;
               end
               if (rsp_tdata[103:76] !== e.next_cluster) begin
                  $error("next_cluster exp %h got %h", e.next_cluster, rsp_tdata[103:76]);
                  fail_count++;
               end
               if (rsp_tdata[105:104] !== e.entry_status) begin
                  $error("entry_status exp %h got %h", e.entry_status,
                         rsp_tdata[105:104]);
                  fail_count++;
               end
               if (rsp_tuser !== e.fat_type) begin
                  $error("fat_type exp %h got %h", e.fat_type, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_lookup(req_kind_type'(req_tuser), req_tdata[31:0], req_tdata[63:32]);
      end
      pending = expected_q.size();
   end
endmodule
`default_nettype wire

// ----- verif/tb_fat_cluster_chain_lookup.sv -----
// Testbench top for the FAT cluster-chain lookup: stimulus, stalls and verdict.
`default_nettype none
module tb_fat_cluster_chain_lookup;
   import fcl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;  // covers geometry pass plus long stalls
   localparam int DRAIN_CYCLES = 30;       // pipeline is 11 deep

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [31:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   int           fail_count, pending, rsp_count;

   int send_idle_pct = 0;   // percent of cycles the sender holds off
   int recv_stall_pct = 0;  // percent of cycles the receiver stalls
   int idle_cycles = 0;
   int items_sent = 0;
   int settings_used = 0;

   always #10 clock = ~clock;

   fat_cluster_chain_lookup dut (.*);

   fcl_checker chk (.*);

   // Receiver: random backpressure driven on the falling edge.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // Watchdog: count cycles with no accepted item on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("[fat_cluster_chain_lookup] ERROR");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Present one item, holding it until the block takes it.
   task automatic send_lookup(input req_kind_type rk, input logic [31:0] clu,
                              input logic [31:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rk;
      req_tdata <= {raw, clu};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Called on a falling edge right after the last item was taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic load_geometry(input logic [31:0] bps, spc, rsvd, nf, root, tot, fsz);
      write_reg(CSR_BPS, bps);
      write_reg(CSR_SPC, spc);
      write_reg(CSR_RSVD, rsvd);
      write_reg(CSR_NFATS, nf);
      write_reg(CSR_ROOT, root);
      write_reg(CSR_TOTAL, tot);
      write_reg(CSR_FATSZ, fsz);
      settings_used++;
   endtask

   // Biased cluster: sometimes small, sometimes near the top, full range otherwise.
   function automatic logic [31:0] pick_cluster();
      case ($urandom_range(3))
         0: return $urandom_range(4095);
         1: return 32'hFFFFFFFF - $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   // Biased raw word: lands on end-of-chain and bad markers often.
   function automatic logic [31:0] pick_raw();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(5))
         0: r[15:0] = {FAT12_BAD, 4'($urandom)};
         1: r[15:0] = {4'($urandom), FAT12_BAD};
         2: r[15:0] = FAT16_BAD;
         3: r[27:0] = FAT32_BAD;
         4: r[27:0] = FAT32_EOC | 28'($urandom_range(7));
         default: ;
      endcase
      return r;
   endfunction

   task automatic random_burst(input int n);
      repeat (n)
         send_lookup(req_kind_type'($urandom_range(1)), pick_cluster(), pick_raw());
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset geometry (FAT32), field extremes and both request kinds.
      send_lookup(REQ_LOCATE, 32'd0, 32'd0);
      send_lookup(REQ_LOCATE, 32'd2, 32'hFFFFFFFF);
      send_lookup(REQ_LOCATE, 32'hFFFFFFFF, 32'd0);
      send_lookup(REQ_DECODE, 32'd2, 32'h0000_0FF7);
      send_lookup(REQ_DECODE, 32'd3, 32'h0000_FF70);
      send_lookup(REQ_DECODE, 32'd4, 32'hFFFF_FFF8);
      send_lookup(REQ_DECODE, 32'd5, 32'hFFFF_FFFF);
      send_lookup(REQ_DECODE, 32'hFFFFFFFF, 32'h0000_0123);
      drain();
      // FAT16 volume, oversize sector clamps to the maximum
      load_geometry(8191, 4, 32, 2, 512, 200000, 200);
      send_lookup(REQ_LOCATE, 32'h7FFF_FFFF, 32'd0);
      send_lookup(REQ_DECODE, 32'd9, 32'h1234_FFF7);
      send_lookup(REQ_DECODE, 32'd9, 32'h0000_FFF8);
      send_lookup(REQ_DECODE, 32'd9, 32'h0000_FFF6);
      drain();
      // FAT32 volume
      load_geometry(512, 8, 32, 2, 0, 32'hFFFF_FFFF, 8000);
      send_lookup(REQ_LOCATE, 32'hFFFF_FFFF, 32'd0);
      send_lookup(REQ_DECODE, 32'd7, 32'hFFFF_FFF7);
      send_lookup(REQ_DECODE, 32'd7, 32'hF000_0000);
      send_lookup(REQ_DECODE, 32'd7, 32'h0FFF_FFF8);
      drain();
      // zero sector size, zero sectors per cluster, negative data area
      load_geometry(0, 0, 65535, 255, 65535, 0, 32'hFFFF_FFFF);
      send_lookup(REQ_LOCATE, 32'h1234_5678, 32'd0);
      send_lookup(REQ_DECODE, 32'd1, 32'hABCD_EF12);
      drain();
      load_geometry(1, 128, 0, 0, 0, 100, 0);  // zero-size data area case
      write_reg(CSR_TOTAL, 32'd0);
      send_lookup(REQ_LOCATE, 32'd1000, 32'd0);
      drain();

      // Random: each idling phase over several fixed and random geometries.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         for (int g = 0; g < 6; g++) begin
            case (g)
               0: load_geometry(512, 1, 1, 2, 224, 2880, 9);  // floppy FAT12
               1: load_geometry(512, 4, 4, 2, 512, 262144, 256);
               2: load_geometry(4096, 128, 32, 2, 0, 32'hFFFF_FFFF, 32'h0010_0000);
               default: load_geometry($urandom_range(1, 8191), $urandom_range(128),
                                      $urandom_range(65535), $urandom_range(255),
                                      $urandom_range(65535), $urandom, $urandom);
            endcase
            random_burst(70);
         end
         // a stretch of plain stalls-off traffic in each phase
         send_idle_pct = 0; recv_stall_pct = 0;
         random_burst(5);
      end

      $display("covered %0d items over %0d geometry settings, %0d responses checked",
               items_sent, settings_used, rsp_count);
      $display("phases: no idling, sender idle, receiver stall, both");
      if (fail_count == 0)
         $display("[fat_cluster_chain_lookup] OK");
      else
         $display("[fat_cluster_chain_lookup] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
